// ===== sv/rld_pkg.sv =====
// Shared types, constants and byte classifiers for the text run-length decoder.
// No dependencies.
`timescale 1ns / 1ps

package rld_pkg;

  localparam int RUN_W = 6;
  localparam logic [RUN_W-1:0] MAX_RUN = RUN_W'(62);

  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One decoded command: an optional run, an optional blank, an optional close.
  typedef struct packed {
    logic [7:0]       run_ch;
    logic [RUN_W-1:0] run_n;
    logic             blank_v;
    logic [7:0]       blank_ch;
    logic             done;
    logic             err;
  } cmd_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_NL) || (b == CHAR_SP);
  endfunction

  // Accumulate one decimal digit, saturating at MAX_RUN.
  function automatic logic [RUN_W-1:0] add_digit(input logic [RUN_W-1:0] rc,
                                                 input logic [7:0] b);
    logic [RUN_W+3:0] v;
    logic [7:0] d;
    d = b - CHAR_ZERO;
    v = {rc, 3'b000} + {2'b00, rc, 1'b0} + {{(RUN_W - 2){1'b0}}, d[3:0]};
    if (v > {4'b0000, MAX_RUN}) begin
      return MAX_RUN;
    end
    return v[RUN_W-1:0];
  endfunction

endpackage

// ===== sv/rld_in_if.sv =====
// Input channel of the run-length decoder: encoded byte and end-of-message flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface rld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_message;

  modport source (output valid, output in_byte, output end_of_message, input ready);
  modport sink (input valid, input in_byte, input end_of_message, output ready);
endinterface

// ===== sv/rld_out_if.sv =====
// Output channel of the run-length decoder: one decoded result per transfer.
// Depends on nothing.
`timescale 1ns / 1ps

interface rld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       last;
  logic       msg_done;
  logic       error;

  modport source (output valid, output out_byte, output out_valid, output last,
                  output msg_done, output error, input ready);
  modport sink (input valid, input out_byte, input out_valid, input last,
                input msg_done, input error, output ready);
endinterface

// ===== sv/rld_front.sv =====
// Front end: parses encoded bytes, tracks run state, issues decode commands.
// Depends on rld_pkg and rld_in_if.
`timescale 1ns / 1ps

module rld_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  rld_in_if.sink        in_i,
  input  logic          full_i,
  output logic          push_o,
  output rld_pkg::cmd_t cmd_o
);

  logic                      mode_q, mode_d;
  logic                      start_q, start_d;
  logic [rld_pkg::RUN_W-1:0] rc_q, rc_d;
  logic                      hd_q, hd_d;
  logic [7:0]                pc_q, pc_d;
  logic                      hp_q, hp_d;
  logic                      err_q, err_d;
  rld_pkg::cmd_t             cmd;

  assign in_i.ready = !full_i;

  always_comb begin
    logic                      m;
    logic [rld_pkg::RUN_W-1:0] rc;
    logic                      hd;
    logic [7:0]                pc;
    logic                      hp;
    logic                      er;
    logic [7:0]                b;
    b   = in_i.in_byte;
    m   = start_q ? rld_pkg::is_digit(b) : mode_q;
    rc  = rc_q;
    hd  = hd_q;
    pc  = pc_q;
    hp  = hp_q;
    er  = err_q;
    cmd = '0;
    if (!er) begin
      if (m) begin
        if (rld_pkg::is_digit(b)) begin
          rc = rld_pkg::add_digit(rc, b);
          hd = 1'b1;
        end else if (rld_pkg::is_blank(b)) begin
          if (hd) begin
            er = 1'b1;
          end else begin
            cmd.blank_v  = 1'b1;
            cmd.blank_ch = b;
          end
        end else if (rld_pkg::is_letter(b) && hd) begin
          cmd.run_ch = b;
          cmd.run_n  = rc;
          rc = '0;
          hd = 1'b0;
        end else begin
          er = 1'b1;
        end
      end else begin
        if (hp && rld_pkg::is_digit(b)) begin
          rc = rld_pkg::add_digit(rc, b);
          hd = 1'b1;
        end else begin
          if (hp) begin
            if (hd) begin
              cmd.run_ch = pc;
              cmd.run_n  = rc;
            end else begin
              er = 1'b1;
            end
          end
          hp = 1'b0;
          pc = '0;
          rc = '0;
          hd = 1'b0;
          if (!er) begin
            if (rld_pkg::is_blank(b)) begin
              cmd.blank_v  = 1'b1;
              cmd.blank_ch = b;
            end else begin
              pc = b;
              hp = 1'b1;
            end
          end
        end
      end
    end
    if (in_i.end_of_message) begin
      if (!er) begin
        if (m) begin
          if (hd) begin
            er = 1'b1;
          end
        end else if (hp) begin
          if (hd) begin
            cmd.run_ch = pc;
            cmd.run_n  = rc;
          end else begin
            er = 1'b1;
          end
        end
      end
      cmd.done = 1'b1;
      cmd.err  = er;
      mode_d   = 1'b0;
      start_d  = 1'b1;
      rc_d     = '0;
      hd_d     = 1'b0;
      pc_d     = '0;
      hp_d     = 1'b0;
      err_d    = 1'b0;
    end else begin
      mode_d  = m;
      start_d = 1'b0;
      rc_d    = rc;
      hd_d    = hd;
      pc_d    = pc;
      hp_d    = hp;
      err_d   = er;
    end
  end

  assign cmd_o  = cmd;
  assign push_o = in_i.valid && in_i.ready &&
                  ((cmd.run_n != '0) || cmd.blank_v || cmd.done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      start_q <= 1'b1;
      rc_q    <= '0;
      hd_q    <= 1'b0;
      pc_q    <= '0;
      hp_q    <= 1'b0;
      err_q   <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      rc_q    <= rc_d;
      hd_q    <= hd_d;
      pc_q    <= pc_d;
      hp_q    <= hp_d;
      err_q   <= err_d;
    end
  end

endmodule

// ===== sv/rld_queue.sv =====
// Short command queue between the parser and the run expander.
// Depends on rld_pkg.
`timescale 1ns / 1ps

module rld_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rld_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output rld_pkg::cmd_t data_o,
  output logic          empty_o
);

  rld_pkg::cmd_t                   mem_q [rld_pkg::QUEUE_DEPTH];
  logic [rld_pkg::QUEUE_PTR_W-1:0] wr_q, wr_d;
  logic [rld_pkg::QUEUE_PTR_W-1:0] rd_q, rd_d;
  logic [rld_pkg::QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == rld_pkg::QUEUE_CNT_W'(rld_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [rld_pkg::QUEUE_PTR_W-1:0] next_ptr(
      input logic [rld_pkg::QUEUE_PTR_W-1:0] p);
    if (p == rld_pkg::QUEUE_PTR_W'(rld_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_d  = do_push ? next_ptr(wr_q) : wr_q;
    rd_d  = do_pop ? next_ptr(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== sv/rld_back.sv =====
// Back end: expands one command into result transfers through an output register.
// Depends on rld_pkg and rld_out_if.
`timescale 1ns / 1ps

module rld_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  rld_pkg::cmd_t cmd_i,
  output logic          pop_o,
  rld_out_if.source     out_o
);

  logic                      busy_q, busy_d;
  logic [rld_pkg::RUN_W-1:0] rem_q, rem_d;
  logic [7:0]                ch_q, ch_d;
  logic                      blank_v_q, blank_v_d;
  logic [7:0]                blank_ch_q, blank_ch_d;
  logic                      done_q, done_d;
  logic                      err_q, err_d;

  logic       ov_q, ov_d;
  logic [7:0] ob_q, ob_d;
  logic       oval_q, oval_d;
  logic       olast_q, olast_d;
  logic       odone_q, odone_d;
  logic       oerr_q, oerr_d;
  logic       emit;

  assign pop_o = !busy_q && !empty_i;
  assign emit  = busy_q && (!ov_q || out_o.ready);

  always_comb begin
    busy_d     = busy_q;
    rem_d      = rem_q;
    ch_d       = ch_q;
    blank_v_d  = blank_v_q;
    blank_ch_d = blank_ch_q;
    done_d     = done_q;
    err_d      = err_q;
    ov_d       = ov_q && !out_o.ready;
    ob_d       = ob_q;
    oval_d     = oval_q;
    olast_d    = olast_q;
    odone_d    = odone_q;
    oerr_d     = oerr_q;
    if (pop_o) begin
      busy_d     = 1'b1;
      rem_d      = cmd_i.run_n;
      ch_d       = cmd_i.run_ch;
      blank_v_d  = cmd_i.blank_v;
      blank_ch_d = cmd_i.blank_ch;
      done_d     = cmd_i.done;
      err_d      = cmd_i.err;
    end else if (emit) begin
      ov_d    = 1'b1;
      odone_d = 1'b0;
      oerr_d  = 1'b0;
      if (rem_q != '0) begin
        ob_d    = ch_q;
        oval_d  = 1'b1;
        olast_d = (rem_q == rld_pkg::RUN_W'(1)) && !blank_v_q && !done_q;
        rem_d   = rem_q - 1'b1;
      end else if (blank_v_q) begin
        ob_d      = blank_ch_q;
        oval_d    = 1'b1;
        olast_d   = !done_q;
        blank_v_d = 1'b0;
      end else begin
        ob_d    = '0;
        oval_d  = 1'b0;
        olast_d = 1'b1;
        odone_d = 1'b1;
        oerr_d  = err_q;
        done_d  = 1'b0;
      end
      busy_d = !olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    ch_q       <= ch_d;
    blank_v_q  <= blank_v_d;
    blank_ch_q <= blank_ch_d;
    done_q     <= done_d;
    err_q      <= err_d;
    ob_q       <= ob_d;
    oval_q     <= oval_d;
    olast_q    <= olast_d;
    odone_q    <= odone_d;
    oerr_q     <= oerr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ov_q   <= ov_d;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.out_byte  = ob_q;
  assign out_o.out_valid = oval_q;
  assign out_o.last      = olast_q;
  assign out_o.msg_done  = odone_q;
  assign out_o.error     = oerr_q;

endmodule

// ===== sv/text_run_length_decoder.sv =====
// Top level of the streaming text run-length decoder.
// Depends on rld_pkg, rld_in_if, rld_out_if, rld_front, rld_queue and rld_back.
`timescale 1ns / 1ps

// The parser takes one encoded byte per cycle and turns it into a command
// (a run of up to 62 copies, a passed-through blank, a message close) that
// waits in a two-entry queue. The expander then sends one result per cycle
// while the output register is not stalled; it loads each command from the
// queue before it sends that command's results, and takes no new one until
// its last result is sent. The parser stalls only when the queue is full.
// Results leave through an output register, and the error flag is set only
// on the closing result of a message. There is no start-up clearing pass.

module text_run_length_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  rld_in_if.sink    in_i,
  rld_out_if.source out_o
);

  logic          push, full, pop, empty;
  rld_pkg::cmd_t push_cmd, head_cmd;

  rld_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  rld_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .empty_o (empty)
  );

  rld_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (head_cmd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.error |-> out_o.msg_done && !out_o.out_valid)
    else $error("error flag outside a closing result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.out_valid |-> out_o.msg_done && out_o.last)
    else $error("non-character result is not a closing last result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.msg_done |-> out_o.out_byte == 8'h00)
    else $error("closing result carries a nonzero byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && full |-> 1'b0)
    else $error("command pushed into a full queue");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the text run-length decoder: directed and random messages
// with gaps on both channels, predicted results compared in order. Depends on rld_pkg,
// rld_in_if, rld_out_if and text_run_length_decoder.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS = 320;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       last;
    logic       msg_done;
    logic       error;
  } dec_result_t;

  class text_decode_checker;
    logic                      count_mode;
    logic                      msg_start;
    logic [rld_pkg::RUN_W-1:0] run_len;
    logic                      digits_seen;
    logic [7:0]                held_char;
    logic                      char_held;
    logic                      err_seen;
    dec_result_t               awaited[$];
    int                        mismatches;
    int                        checked;
    int                        messages;
    int                        count_first_msgs;
    int                        flagged_msgs;
    int                        longest_run;

    function new();
      clear_state();
      mismatches = 0;
      checked = 0;
      messages = 0;
      count_first_msgs = 0;
      flagged_msgs = 0;
      longest_run = 0;
    endfunction

    function void clear_state();
      count_mode = 1'b0;
      msg_start = 1'b1;
      run_len = '0;
      digits_seen = 1'b0;
      held_char = 8'h00;
      char_held = 1'b0;
      err_seen = 1'b0;
    endfunction

    function bit is_num(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit is_alpha(logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function bit is_space(logic [7:0] b);
      return b == rld_pkg::CHAR_NL || b == rld_pkg::CHAR_SP;
    endfunction

    function void push(logic [7:0] ch, logic v, logic done);
      dec_result_t r;
      r.out_byte = ch;
      r.out_valid = v;
      r.last = 1'b0;
      r.msg_done = done;
      r.error = err_seen;
      awaited.push_back(r);
    endfunction

    function void add_digit(logic [7:0] b);
      int v;
      v = int'(run_len) * 10 + int'(b - rld_pkg::CHAR_ZERO);
      if (v > int'(rld_pkg::MAX_RUN)) v = int'(rld_pkg::MAX_RUN);
      run_len = v[rld_pkg::RUN_W-1:0];
      digits_seen = 1'b1;
    endfunction

    function void emit_run(logic [7:0] ch);
      if (int'(run_len) > longest_run) longest_run = int'(run_len);
      for (int i = 0; i < int'(run_len); i++) push(ch, 1'b1, 1'b0);
      run_len = '0;
      digits_seen = 1'b0;
    endfunction

    function void close_run();
      if (char_held) begin
        if (digits_seen) emit_run(held_char);
        else err_seen = 1'b1;
      end
      char_held = 1'b0;
      held_char = 8'h00;
      run_len = '0;
      digits_seen = 1'b0;
    endfunction

    function void count_first_byte(logic [7:0] b);
      if (is_num(b)) begin
        add_digit(b);
      end else if (is_space(b)) begin
        if (digits_seen) err_seen = 1'b1;
        else push(b, 1'b1, 1'b0);
      end else if (is_alpha(b) && digits_seen) begin
        emit_run(b);
      end else begin
        err_seen = 1'b1;
      end
    endfunction

    function void letter_first_byte(logic [7:0] b);
      if (char_held && is_num(b)) begin
        add_digit(b);
      end else begin
        close_run();
        if (!err_seen) begin
          if (is_space(b)) begin
            push(b, 1'b1, 1'b0);
          end else begin
            held_char = b;
            char_held = 1'b1;
          end
        end
      end
    endfunction

    function void accept_byte(logic [7:0] b, logic eom);
      int before_n;
      dec_result_t r;
      before_n = awaited.size();
      if (msg_start) begin
        count_mode = is_num(b);
        msg_start = 1'b0;
        if (count_mode) count_first_msgs++;
      end
      if (!err_seen) begin
        if (count_mode) count_first_byte(b);
        else letter_first_byte(b);
      end
      if (eom) begin
        if (!err_seen) begin
          if (count_mode) begin
            if (digits_seen) err_seen = 1'b1;
          end else begin
            close_run();
          end
        end
        push(8'h00, 1'b0, 1'b1);
        messages++;
        if (err_seen) flagged_msgs++;
        clear_state();
      end
      if (awaited.size() > before_n) begin
        r = awaited.pop_back();
        r.last = 1'b1;
        awaited.push_back(r);
      end
    endfunction

    function void compare_result(logic [7:0] ch, logic v, logic lst, logic done, logic er);
      dec_result_t want;
      checked++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: byte %h valid %b last %b done %b error %b",
                   ch, v, lst, done, er);
      end else begin
        want = awaited.pop_front();
        if (want.out_byte !== ch || want.out_valid !== v || want.last !== lst ||
            want.msg_done !== done || want.error !== er) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: expected byte %h valid %b last %b done %b error %b, ",
                      "got byte %h valid %b last %b done %b error %b"},
                     want.out_byte, want.out_valid, want.last, want.msg_done, want.error,
                     ch, v, lst, done, er);
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rld_in_if  in_bus ();
  rld_out_if out_bus ();

  text_run_length_decoder i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  text_decode_checker sb = new();

  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         bytes_sent = 0;
  logic [7:0] msg_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid && in_bus.ready)
      sb.accept_byte(in_bus.in_byte, in_bus.end_of_message);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      sb.compare_result(out_bus.out_byte, out_bus.out_valid, out_bus.last,
                        out_bus.msg_done, out_bus.error);
    out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic eom);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.in_byte <= b;
    in_bus.end_of_message <= eom;
    do @(posedge clk_i); while (!in_bus.ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 75) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, 15);
    if (r < 96) return $urandom_range(16, 62);
    return $urandom_range(63, 999);
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 1) == 0) return 8'("A" + $urandom_range(0, 25));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_held_char();
    logic [7:0] b;
    if ($urandom_range(0, 99) < 85) return pick_letter();
    b = 8'($urandom_range(0, 255));
    while ((b >= "0" && b <= "9") || b == rld_pkg::CHAR_NL || b == rld_pkg::CHAR_SP)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] pick_blank();
    return ($urandom_range(0, 1) == 0) ? rld_pkg::CHAR_SP : rld_pkg::CHAR_NL;
  endfunction

  function automatic void append_count(int n);
    string s;
    s = $sformatf("%0d", n);
    if ($urandom_range(0, 9) == 0) msg_q.push_back("0");
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endfunction

  function automatic void build_count_first();
    int runs;
    runs = $urandom_range(1, 4);
    msg_q.delete();
    for (int i = 0; i < runs; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0) msg_q.push_back(pick_blank());
      append_count(pick_count());
      msg_q.push_back(pick_letter());
    end
    if ($urandom_range(0, 3) == 0) msg_q.push_back(pick_blank());
  endfunction

  function automatic void build_letter_first();
    int runs;
    runs = $urandom_range(1, 4);
    msg_q.delete();
    if ($urandom_range(0, 9) == 0) msg_q.push_back(pick_blank());
    for (int i = 0; i < runs; i++) begin
      msg_q.push_back(pick_held_char());
      append_count(pick_count());
      if ($urandom_range(0, 2) == 0) msg_q.push_back(pick_blank());
    end
  endfunction

  function automatic void corrupt_message();
    case ($urandom_range(0, 3))
      0: if (msg_q.size() > 1) msg_q.delete($urandom_range(0, msg_q.size() - 1));
      1: msg_q.insert($urandom_range(0, msg_q.size() - 1), 8'($urandom_range(0, 255)));
      2: msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
      default: begin
        msg_q.delete();
        repeat ($urandom_range(1, 5)) msg_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  function automatic void apply_phase(int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
      default: begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
  endfunction

  initial begin
    int start_n;
    int phase;
    int next_phase;
    in_bus.valid <= 1'b0;
    in_bus.in_byte <= 8'h00;
    in_bus.end_of_message <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("3a 1b");
    send_text("b2 c0");
    send_text("99z\n");
    send_text("a1 52");
    send_text("ab1");
    send_text("2ab");
    send_text("5\n");
    send_text("7");
    send_byte(8'hFF, 1'b1);

    start_n = bytes_sent;
    phase = 0;
    apply_phase(phase);
    while (bytes_sent - start_n < RANDOM_ITEMS) begin
      next_phase = (bytes_sent - start_n) * 4 / RANDOM_ITEMS;
      if (next_phase != phase) begin
        phase = next_phase;
        apply_phase(phase);
        if (phase == 2) drain();
      end
      if ($urandom_range(0, 1) == 0) build_count_first();
      else build_letter_first();
      if ($urandom_range(0, 99) >= 70) corrupt_message();
      send_message();
    end

    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("sent %0d bytes in %0d messages (%0d count-first, %0d flagged malformed)",
             bytes_sent, sb.messages, sb.count_first_msgs, sb.flagged_msgs);
    $display("checked %0d results, longest run %0d, %0d mismatches",
             sb.checked, sb.longest_run, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
